@@ rtl/core/qscp_pkg.sv @@
// Shared types, widths and helpers for the quad shadow coordinate projector.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package qscp_pkg;

  // Fixed field widths
  localparam int CoordW = 32;
  localparam int NormW  = 18;
  localparam int CfgIdxW = 2;

  // Shared multiplier and accumulator
  localparam int MulAW = 34;
  localparam int MulBW = 32;
  localparam int ProdW = MulAW + MulBW;
  localparam int AccW  = 67;

  // Square root and length
  localparam int SqW  = 64;
  localparam int LenW = 32;

  // Sequencer step counter
  localparam int StepW = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_BALL_X = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BALL_Y = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BALL_Z = 2'd2;

  // Coefficient sets of the projection
  localparam logic [1:0] SET_U = 2'd0;
  localparam logic [1:0] SET_V = 2'd1;
  localparam logic [1:0] SET_N = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_EDGE,
    OP_MAG,
    OP_SHIFT,
    OP_SQRT_START,
    OP_SQRT_STEP,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_STORE,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [1:0] {
    SEQ_SQ,
    SEQ_CROSS,
    SEQ_DOT
  } seq_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EDGE,
    ST_MAG,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_SQRT_RUN,
    ST_DIV,
    ST_DIV_RUN,
    ST_STORE,
    ST_CROSS,
    ST_PROJ,
    ST_EMIT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e           op;
    seq_e             seq;
    logic             mul_en;
    logic [StepW-1:0] mul_j;
    logic             acc_en;
    logic [StepW-1:0] acc_j;
    logic [1:0]       comp;
    logic             tgt_v;
    logic             proj_cur;
    logic [1:0]       corner;
    logic             last;
  } dp_cmd_t;

  typedef struct packed {
    logic last;
    logic shift_done;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } dp_status_t;

  // (a + b) mod 3 for component indexes
  function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  // Dot sequence step -> coefficient set
  function automatic logic [1:0] dot_set(input logic [StepW-1:0] j);
    logic [1:0] r;
    case (j)
      4'd0, 4'd1, 4'd2: r = SET_U;
      4'd3, 4'd4, 4'd5: r = SET_V;
      default:          r = SET_N;
    endcase
    return r;
  endfunction

  // Dot sequence step -> vector component
  function automatic logic [1:0] dot_comp(input logic [StepW-1:0] j);
    logic [StepW-1:0] r;
    r = j - StepW'(dot_set(j)) * StepW'(3);
    return r[1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/qscp_if.sv @@
// Valid/ready channels of the projector: vertex input and result output.
// Depends on qscp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface qscp_vtx_if import qscp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] vert_x;
  logic signed [CoordW-1:0] vert_y;
  logic signed [CoordW-1:0] vert_z;
  logic signed [NormW-1:0]  norm_x;
  logic signed [NormW-1:0]  norm_y;
  logic signed [NormW-1:0]  norm_z;
  logic                     end_of_pass;

  modport source (output valid, vert_x, vert_y, vert_z, norm_x, norm_y, norm_z,
                  end_of_pass, input ready);
  modport sink (input valid, vert_x, vert_y, vert_z, norm_x, norm_y, norm_z,
                end_of_pass, output ready);
endinterface

interface qscp_res_if import qscp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] shadow_s;
  logic signed [CoordW-1:0] shadow_t;
  logic signed [CoordW-1:0] shadow_r;
  logic [1:0]               corner_index;
  logic                     last_of_pass;

  modport source (output valid, shadow_s, shadow_t, shadow_r, corner_index,
                  last_of_pass, input ready);
  modport sink (input valid, shadow_s, shadow_t, shadow_r, corner_index,
                last_of_pass, output ready);
endinterface

`default_nettype wire

@@ rtl/core/quad_shadow_coord_projection.sv @@
// Quad shadow coordinate projector top level: controller plus datapath.
// Depends on qscp_pkg, qscp_if, qscp_ctrl and qscp_dp.
//
// Usage: vertices arrive on vtx_i, four per quad, the face normal with each
// (read on the first corner). The ball position is written through the
// cfg_we_i / cfg_idx_i / cfg_data_i port while the block is idle.
// Results (s, t, r, corner, last flag) leave on res_o through one output
// register; the next vertex is taken while that register still waits.
// The first corner gives no result unless it ends the pass; the second
// corner gives two results, the first corner's then its own.
// Corners two and three pass through capture, one decision state, ten
// steps of the shared multiplier (nine products) and the output load.
// The second corner builds the frame: two normalizations, each with
// pre-scaling shifts, a 32-step square root and three bit-serial
// divisions of FRAC_BITS+32 steps.
// One vertex is worked on at a time; vtx_i.ready is high only when idle.
// Reset clears the corner count, the ball position and the output valid.
// A stalled receiver holds the result register and the block waits at its
// next result until the register frees.
`timescale 1ns / 1ps
`default_nettype none

module quad_shadow_coord_projection import qscp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  qscp_vtx_if.sink           vtx_i,
  qscp_res_if.source         res_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_data_i
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  logic       vtx_ready;

  assign vtx_i.ready = vtx_ready;

  qscp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vtx_valid_i (vtx_i.valid),
    .vtx_ready_o (vtx_ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  qscp_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (dp_cmd),
    .status_o       (dp_status),
    .vert_x_i       (vtx_i.vert_x),
    .vert_y_i       (vtx_i.vert_y),
    .vert_z_i       (vtx_i.vert_z),
    .norm_x_i       (vtx_i.norm_x),
    .norm_y_i       (vtx_i.norm_y),
    .norm_z_i       (vtx_i.norm_z),
    .end_of_pass_i  (vtx_i.end_of_pass),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (res_o.ready),
    .out_valid_o    (res_o.valid),
    .shadow_s_o     (res_o.shadow_s),
    .shadow_t_o     (res_o.shadow_t),
    .shadow_r_o     (res_o.shadow_r),
    .corner_index_o (res_o.corner_index),
    .last_of_pass_o (res_o.last_of_pass)
  );

  // One vertex in flight: no second transfer right after a capture
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_i.valid && vtx_ready |=> !vtx_ready)
    else $error("vertex taken while previous one in work");

  // A result is only loaded into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.op == OP_EMIT |-> dp_status.out_free)
    else $error("output register overwritten");

  // Divider never steps past its last quotient bit
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.op == OP_DIV_STEP |-> !dp_status.div_done)
    else $error("divider overran");

endmodule

`default_nettype wire

@@ rtl/core/qscp_dp.sv @@
// Datapath: vertex/frame registers, shared multiplier-accumulator, iterative
// square root and divider, result and output registers. Uses qscp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qscp_dp import qscp_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_status_t               status_o,
  input  logic signed [CoordW-1:0] vert_x_i,
  input  logic signed [CoordW-1:0] vert_y_i,
  input  logic signed [CoordW-1:0] vert_z_i,
  input  logic signed [NormW-1:0]  norm_x_i,
  input  logic signed [NormW-1:0]  norm_y_i,
  input  logic signed [NormW-1:0]  norm_z_i,
  input  logic                     end_of_pass_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CoordW-1:0]        cfg_data_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic signed [CoordW-1:0] shadow_s_o,
  output logic signed [CoordW-1:0] shadow_t_o,
  output logic signed [CoordW-1:0] shadow_r_o,
  output logic [1:0]               corner_index_o,
  output logic                     last_of_pass_o
);

  localparam int CoefW = FRAC_BITS + 2;
  localparam int WorkW = (FRAC_BITS + 20 > 34) ? FRAC_BITS + 20 : 34;
  localparam int NumW  = 32 + FRAC_BITS;
  localparam int CntW  = $clog2(NumW + 1);
  localparam logic signed [AccW-1:0] RndOff     = AccW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [AccW-1:0] RndHalfOff = RndOff + (AccW'(1) <<< (2 * FRAC_BITS - 1));

  logic signed [CoordW-1:0] ball_q [3];
  logic signed [CoordW-1:0] first_q [3];
  logic signed [CoordW-1:0] vert_q [3];
  logic signed [NormW-1:0]  norm_q [3];
  logic                     last_q;
  logic signed [CoefW-1:0]  u_q [3];
  logic signed [CoefW-1:0]  v_q [3];
  logic signed [WorkW-1:0]  w_q [3];
  logic [WorkW-1:0]         m_q [3];
  logic                     neg_q [3];
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q;
  logic [SqW-1:0]           sq_x_q, sq_res_q, sq_bit_q;
  logic [LenW:0]            rem_q;
  logic [NumW-1:0]          num_q, quo_q;
  logic [CntW-1:0]          cnt_q;
  logic signed [CoordW-1:0] res_q [3];
  logic                     out_valid_q;
  logic signed [CoordW-1:0] out_s_q, out_t_q, out_r_q;
  logic [1:0]               out_corner_q;
  logic                     out_last_q;

  logic signed [CoordW:0]   d_vec [3];
  logic signed [CoordW:0]   e_vec [3];
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod_d;
  logic signed [AccW-1:0]   prod_ext, acc_d, acc_sh;
  logic signed [CoordW-1:0] sat_val;
  logic [1:0]               x_c, x_i1, x_i2, dt_set, dt_comp, a_set, a_comp;
  logic [SqW-1:0]           sq_trial;
  logic [LenW-1:0]          len;
  logic [LenW:0]            rem_sh;
  logic signed [CoefW-1:0]  q_s, q_val;

  assign len = sq_res_q[LenW-1:0];

  // Difference vectors: ball minus projected vertex, edge of the quad
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_vec[i] = (CoordW+1)'(ball_q[i]) -
                 (CoordW+1)'(cmd_i.proj_cur ? vert_q[i] : first_q[i]);
      e_vec[i] = (CoordW+1)'(vert_q[i]) - (CoordW+1)'(first_q[i]);
    end
  end

  // Multiplier operand selection
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    x_c     = cmd_i.mul_j[2:1];
    x_i1    = mod3_add(x_c, cmd_i.mul_j[0] ? 2'd2 : 2'd1);
    x_i2    = mod3_add(x_c, cmd_i.mul_j[0] ? 2'd1 : 2'd2);
    dt_set  = dot_set(cmd_i.mul_j);
    dt_comp = dot_comp(cmd_i.mul_j);
    unique case (cmd_i.seq)
      SEQ_SQ: begin
        mul_a = signed'({3'b000, m_q[cmd_i.mul_j[1:0]][30:0]});
        mul_b = signed'({1'b0, m_q[cmd_i.mul_j[1:0]][30:0]});
      end
      SEQ_CROSS: begin
        mul_a = MulAW'(u_q[x_i1]);
        mul_b = MulBW'(norm_q[x_i2]);
      end
      SEQ_DOT: begin
        mul_a = MulAW'(d_vec[dt_comp]);
        if (dt_set == SET_U) begin
          mul_b = MulBW'(u_q[dt_comp]);
        end else if (dt_set == SET_V) begin
          mul_b = MulBW'(v_q[dt_comp]);
        end else begin
          mul_b = MulBW'(norm_q[dt_comp]);
        end
      end
      default: ;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // Accumulator update; the dot rounding offset rides in with the first term
  always_comb begin
    a_set    = dot_set(cmd_i.acc_j);
    a_comp   = dot_comp(cmd_i.acc_j);
    prod_ext = AccW'(prod_q);
    unique case (cmd_i.seq)
      SEQ_SQ:    acc_d = (cmd_i.acc_j == '0) ? prod_ext : acc_q + prod_ext;
      SEQ_CROSS: acc_d = cmd_i.acc_j[0] ? acc_q - prod_ext : prod_ext;
      SEQ_DOT: begin
        if (a_comp == 2'd0) begin
          acc_d = prod_ext + ((a_set == SET_N) ? RndOff : RndHalfOff);
        end else begin
          acc_d = acc_q + prod_ext;
        end
      end
      default:   acc_d = acc_q;
    endcase
    acc_sh = acc_d >>> FRAC_BITS;
    if ((&acc_sh[AccW-1:CoordW-1]) || !(|acc_sh[AccW-1:CoordW-1])) begin
      sat_val = acc_sh[CoordW-1:0];
    end else begin
      sat_val = acc_sh[AccW-1] ? signed'({1'b1, {(CoordW-1){1'b0}}})
                               : signed'({1'b0, {(CoordW-1){1'b1}}});
    end
  end

  // Multiply and accumulate registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.acc_en) begin
      acc_q <= acc_d;
      if (cmd_i.seq == SEQ_CROSS && cmd_i.acc_j[0]) begin
        w_q[cmd_i.acc_j[2:1]] <= acc_d[WorkW-1:0];
      end
      if (cmd_i.seq == SEQ_DOT && a_comp == 2'd2) begin
        res_q[a_set] <= sat_val;
      end
    end
    if (cmd_i.op == OP_EDGE) begin
      for (int i = 0; i < 3; i++) begin
        w_q[i] <= WorkW'(e_vec[i]);
      end
    end
  end

  // Ball position configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ball_q <= '{default: '0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BALL_X: ball_q[0] <= signed'(cfg_data_i);
        CFG_BALL_Y: ball_q[1] <= signed'(cfg_data_i);
        CFG_BALL_Z: ball_q[2] <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Vertex, normal and pass flag capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) begin
      vert_q <= '{vert_x_i, vert_y_i, vert_z_i};
      last_q <= end_of_pass_i;
      if (cmd_i.corner == 2'd0) begin
        first_q <= '{vert_x_i, vert_y_i, vert_z_i};
        norm_q  <= '{norm_x_i, norm_y_i, norm_z_i};
      end
    end
  end

  // Magnitudes and pre-scaling shift
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_MAG) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= w_q[i][WorkW-1];
        m_q[i]   <= w_q[i][WorkW-1] ? WorkW'(-w_q[i]) : WorkW'(w_q[i]);
      end
    end else if (cmd_i.op == OP_SHIFT) begin
      for (int i = 0; i < 3; i++) begin
        m_q[i] <= m_q[i] >> 1;
      end
    end
  end

  // Square root, two bits of the radicand per cycle
  assign sq_trial = sq_res_q + sq_bit_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_SQRT_START) begin
      sq_x_q   <= acc_q[SqW-1:0];
      sq_res_q <= '0;
      sq_bit_q <= SqW'(1) << (SqW - 2);
    end else if (cmd_i.op == OP_SQRT_STEP) begin
      if (sq_x_q >= sq_trial) begin
        sq_x_q   <= sq_x_q - sq_trial;
        sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
      end else begin
        sq_res_q <= sq_res_q >> 1;
      end
      sq_bit_q <= sq_bit_q >> 2;
    end
  end

  // Restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_q[LenW-1:0], num_q[NumW-1]};
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_DIV_START) begin
      num_q <= (NumW'(m_q[cmd_i.comp][30:0]) << FRAC_BITS) + NumW'(len >> 1);
      rem_q <= '0;
      quo_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.op == OP_DIV_STEP) begin
      if (rem_sh >= {1'b0, len}) begin
        rem_q <= rem_sh - {1'b0, len};
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
      num_q <= num_q << 1;
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // Signed, zero-guarded frame component
  always_comb begin
    q_s = signed'({1'b0, quo_q[CoefW-2:0]});
    if (len == '0) begin
      q_val = '0;
    end else begin
      q_val = neg_q[cmd_i.comp] ? -q_s : q_s;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_STORE) begin
      if (cmd_i.tgt_v) begin
        v_q[cmd_i.comp] <= q_val;
      end else begin
        u_q[cmd_i.comp] <= q_val;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      out_s_q      <= res_q[SET_U];
      out_t_q      <= res_q[SET_V];
      out_r_q      <= res_q[SET_N];
      out_corner_q <= cmd_i.corner;
      out_last_q   <= cmd_i.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign shadow_s_o     = out_s_q;
  assign shadow_t_o     = out_t_q;
  assign shadow_r_o     = out_r_q;
  assign corner_index_o = out_corner_q;
  assign last_of_pass_o = out_last_q;

  // Status back to the controller
  assign status_o.last       = last_q;
  assign status_o.shift_done = (m_q[0][WorkW-1:31] == '0) && (m_q[1][WorkW-1:31] == '0) &&
                               (m_q[2][WorkW-1:31] == '0);
  assign status_o.sqrt_done  = (sq_bit_q == '0);
  assign status_o.div_done   = (cnt_q == CntW'(NumW));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

@@ rtl/core/qscp_ctrl.sv @@
// Controller: sequences vertex capture, frame build, projection and emit.
// Drives the datapath through dp_cmd_t and reads dp_status_t (qscp_pkg).
`timescale 1ns / 1ps
`default_nettype none

module qscp_ctrl import qscp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       vtx_valid_i,
  output logic       vtx_ready_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [1:0]       corner_q, corner_d;
  logic [1:0]       k_q, k_d;
  logic [StepW-1:0] step_q, step_d;
  logic             tgt_v_q, tgt_v_d;
  logic             cur_q, cur_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      corner_q <= '0;
      k_q      <= '0;
      step_q   <= '0;
      tgt_v_q  <= 1'b0;
      cur_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      corner_q <= corner_d;
      k_q      <= k_d;
      step_q   <= step_d;
      tgt_v_q  <= tgt_v_d;
      cur_q    <= cur_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d  = state_q;
    corner_d = corner_q;
    k_d      = k_q;
    step_d   = step_q;
    tgt_v_d  = tgt_v_q;
    cur_d    = cur_q;

    vtx_ready_o    = 1'b0;
    cmd_o          = '0;
    cmd_o.op       = OP_NONE;
    cmd_o.seq      = SEQ_SQ;
    cmd_o.mul_j    = step_q;
    cmd_o.acc_j    = step_q - 1'b1;
    cmd_o.comp     = k_q;
    cmd_o.tgt_v    = tgt_v_q;
    cmd_o.proj_cur = cur_q;
    cmd_o.corner   = corner_q;

    unique case (state_q)
      ST_IDLE: begin
        vtx_ready_o = 1'b1;
        if (vtx_valid_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (corner_q == 2'd0 && !status_i.last) begin
          corner_d = 2'd1;
          state_d  = ST_IDLE;
        end else if (corner_q == 2'd0 || corner_q == 2'd1) begin
          tgt_v_d = 1'b0;
          state_d = ST_EDGE;
        end else begin
          cur_d   = 1'b1;
          step_d  = '0;
          state_d = ST_PROJ;
        end
      end
      ST_EDGE: begin
        cmd_o.op = OP_EDGE;
        state_d  = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.op = OP_MAG;
        state_d  = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (status_i.shift_done) begin
          step_d  = '0;
          state_d = ST_SQ;
        end else begin
          cmd_o.op = OP_SHIFT;
        end
      end
      // sum of squares: three products, each accumulated in the next cycle
      ST_SQ: begin
        cmd_o.seq    = SEQ_SQ;
        cmd_o.mul_en = (step_q < StepW'(3));
        cmd_o.acc_en = (step_q != '0);
        if (step_q == StepW'(3)) begin
          state_d = ST_SQRT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT_START;
        k_d      = '0;
        state_d  = ST_SQRT_RUN;
      end
      ST_SQRT_RUN: begin
        if (status_i.sqrt_done) begin
          state_d = ST_DIV;
        end else begin
          cmd_o.op = OP_SQRT_STEP;
        end
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_START;
        state_d  = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        if (status_i.div_done) begin
          state_d = ST_STORE;
        end else begin
          cmd_o.op = OP_DIV_STEP;
        end
      end
      ST_STORE: begin
        cmd_o.op = OP_STORE;
        if (k_q == 2'd2) begin
          step_d = '0;
          if (!tgt_v_q) begin
            tgt_v_d = 1'b1;
            state_d = ST_CROSS;
          end else begin
            cur_d   = 1'b0;
            state_d = ST_PROJ;
          end
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_DIV;
        end
      end
      // u x n, two products per component
      ST_CROSS: begin
        cmd_o.seq    = SEQ_CROSS;
        cmd_o.mul_en = (step_q < StepW'(6));
        cmd_o.acc_en = (step_q != '0);
        if (step_q == StepW'(6)) begin
          state_d = ST_MAG;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      // three dot products of three terms each
      ST_PROJ: begin
        cmd_o.seq    = SEQ_DOT;
        cmd_o.mul_en = (step_q < StepW'(9));
        cmd_o.acc_en = (step_q != '0);
        if (step_q == StepW'(9)) begin
          state_d = ST_EMIT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op = OP_EMIT;
          if (!cur_q) begin
            // first corner's result, held back until the frame exists
            cmd_o.corner = 2'd0;
            cmd_o.last   = (corner_q == 2'd0);
            if (corner_q == 2'd0) begin
              state_d = ST_IDLE;
            end else begin
              cur_d   = 1'b1;
              step_d  = '0;
              state_d = ST_PROJ;
            end
          end else begin
            cmd_o.corner = corner_q;
            cmd_o.last   = status_i.last;
            corner_d     = status_i.last ? 2'd0 : corner_q + 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the quad shadow coordinate projector.
// Needs qscp_pkg, qscp_if and the quad_shadow_coord_projection RTL; the
// expected s/t/r values come from a fixed-point predictor kept in this file.
`timescale 1ns / 1ps

module testbench;
  import qscp_pkg::*;

  localparam int Frac      = 16;
  localparam int Limit     = 3000000;
  localparam int DrainWait = 700;
  localparam int NumRandom = 1400;

  typedef logic signed [63:0] s64;

  typedef struct packed {
    logic signed [31:0] x, y, z;
    logic signed [17:0] nx, ny, nz;
    logic               eop;
  } vertex_t;

  typedef struct packed {
    logic [31:0] s, t, r;
    logic [1:0]  corner;
    logic        last;
  } shadow_t;

  typedef struct packed {
    vertex_t vtx;
    logic    chk;
    shadow_t exp;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CoordW-1:0]  cfg_data_i;

  qscp_vtx_if vtx ();
  qscp_res_if res ();

  quad_shadow_coord_projection u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vtx_i     (vtx),
    .res_o     (res),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // Predictor state
  s64       ball [3];
  logic [1:0] corner_cnt;
  s64       first_v [3];
  s64       fnorm [3];
  s64       frame_u [3];
  s64       frame_v [3];

  shadow_t  pending_shadow [$];
  int       n_fail;
  int       n_vtx;
  int       n_res;
  int       cycles;
  bit       long_hold_done;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [63:0] isqrt(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Shift down below 2^31, integer length, rounded per-component divide
  task automatic unit_vec(input s64 a [3], output s64 o [3]);
    logic [63:0] m [3];
    logic [63:0] sum, len, q;
    for (int i = 0; i < 3; i++) m[i] = (a[i] < 0) ? 64'(-a[i]) : 64'(a[i]);
    while (m[0] >= 64'h8000_0000 || m[1] >= 64'h8000_0000 || m[2] >= 64'h8000_0000)
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = isqrt(sum);
    for (int i = 0; i < 3; i++) begin
      if (len == 0) begin
        o[i] = 0;
      end else begin
        q = ((m[i] << Frac) + len / 2) / len;
        o[i] = (a[i] < 0) ? -s64'(q) : s64'(q);
      end
    end
  endtask

  function automatic logic [31:0] round_sat(input s64 x, input s64 add);
    s64 y;
    y = ((x + (s64'(1) <<< (Frac - 1))) >>> Frac) + add;
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
    return y[31:0];
  endfunction

  function automatic shadow_t project(input s64 v [3], input logic [1:0] c, input logic l);
    s64 d [3];
    s64 du, dv, dn;
    shadow_t o;
    for (int i = 0; i < 3; i++) d[i] = ball[i] - v[i];
    du = frame_u[0] * d[0] + frame_u[1] * d[1] + frame_u[2] * d[2];
    dv = frame_v[0] * d[0] + frame_v[1] * d[1] + frame_v[2] * d[2];
    dn = fnorm[0] * d[0] + fnorm[1] * d[1] + fnorm[2] * d[2];
    o.s = round_sat(du, s64'(1) <<< (Frac - 1));
    o.t = round_sat(dv, s64'(1) <<< (Frac - 1));
    o.r = round_sat(dn, 0);
    o.corner = c;
    o.last = l;
    return o;
  endfunction

  task automatic build_frame(input s64 v1 [3]);
    s64 e [3];
    s64 c [3];
    for (int i = 0; i < 3; i++) e[i] = v1[i] - first_v[i];
    unit_vec(e, frame_u);
    c[0] = frame_u[1] * fnorm[2] - frame_u[2] * fnorm[1];
    c[1] = frame_u[2] * fnorm[0] - frame_u[0] * fnorm[2];
    c[2] = frame_u[0] * fnorm[1] - frame_u[1] * fnorm[0];
    unit_vec(c, frame_v);
  endtask

  // Advance the predictor by one vertex; queue what it yields
  task automatic predict_vertex(input vertex_t it, input logic chk, input shadow_t ex);
    s64 v [3];
    shadow_t p;
    v[0] = it.x;
    v[1] = it.y;
    v[2] = it.z;
    if (corner_cnt == 0) begin
      first_v = v;
      fnorm[0] = it.nx;
      fnorm[1] = it.ny;
      fnorm[2] = it.nz;
      if (it.eop) begin
        build_frame(v);
        p = project(first_v, 2'd0, 1'b1);
        pending_shadow.push_back(chk ? ex : p);
        corner_cnt = 0;
      end else begin
        corner_cnt = 1;
      end
    end else begin
      if (corner_cnt == 1) begin
        build_frame(v);
        pending_shadow.push_back(project(first_v, 2'd0, 1'b0));
      end
      p = project(v, corner_cnt, it.eop);
      pending_shadow.push_back(chk ? ex : p);
      corner_cnt = it.eop ? 2'd0 : corner_cnt + 2'd1;
    end
  endtask

  // Mostly short gaps, a few long ones
  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Vertex transfer: called and returns at a falling edge
  task automatic send_vertex(input vertex_t it, input logic chk, input shadow_t ex);
    int g;
    g = rand_gap();
    if (g > 0) begin
      vtx.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    vtx.vert_x = it.x;
    vtx.vert_y = it.y;
    vtx.vert_z = it.z;
    vtx.norm_x = it.nx;
    vtx.norm_y = it.ny;
    vtx.norm_z = it.nz;
    vtx.end_of_pass = it.eop;
    vtx.valid = 1'b1;
    do @(posedge clk_i); while (!vtx.ready);
    predict_vertex(it, chk, ex);
    n_vtx++;
    @(negedge clk_i);
  endtask

  // Wait until all results are in, then let the block settle
  task automatic drain();
    vtx.valid = 1'b0;
    while (pending_shadow.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_ball(input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz);
    logic [31:0] vals [3];
    logic [CfgIdxW-1:0] idx [3];
    vals = '{bx, by, bz};
    idx = '{CFG_BALL_X, CFG_BALL_Y, CFG_BALL_Z};
    for (int i = 0; i < 3; i++) begin
      cfg_we_i = 1'b1;
      cfg_idx_i = idx[i];
      cfg_data_i = vals[i];
      ball[i] = s64'($signed(vals[i]));
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $signed(32'($urandom_range(0, 32'h3F_FFFF))) - 32'sh20_0000;
    if (r < 90) return $signed($urandom());
    if (r < 95) return 32'sh7FFF_FFFF;
    return 32'sh8000_0000;
  endfunction

  function automatic logic signed [17:0] rand_norm_comp(input int mode);
    if (mode == 0) return 18'sd0;
    if (mode == 1) return 18'sd65536;
    if (mode == 2) return -18'sd65536;
    if (mode == 3) return 18'($urandom_range(0, 131072)) - 18'sd65536;
    return 18'($urandom());
  endfunction

  function automatic vertex_t rand_vertex();
    vertex_t v;
    int ax, m;
    v.x = rand_coord();
    v.y = rand_coord();
    v.z = rand_coord();
    ax = $urandom_range(0, 2);
    m = $urandom_range(0, 9);
    if (m < 6) begin
      // axis-aligned unit normal
      v.nx = (ax == 0) ? rand_norm_comp($urandom_range(1, 2)) : 18'sd0;
      v.ny = (ax == 1) ? rand_norm_comp($urandom_range(1, 2)) : 18'sd0;
      v.nz = (ax == 2) ? rand_norm_comp($urandom_range(1, 2)) : 18'sd0;
    end else if (m < 9) begin
      v.nx = rand_norm_comp(3);
      v.ny = rand_norm_comp(3);
      v.nz = rand_norm_comp(3);
    end else begin
      v.nx = rand_norm_comp(4);
      v.ny = rand_norm_comp(4);
      v.nz = rand_norm_comp(4);
    end
    v.eop = ($urandom_range(0, 99) < 5);
    return v;
  endfunction

  // Result receiver: random ready, one long hold-off
  initial begin
    int g;
    int held;
    res.ready = 1'b0;
    long_hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && n_res >= 100) begin
        long_hold_done = 1'b1;
        res.ready = 1'b0;
        held = 0;
        while (held < 3000) begin
          @(negedge clk_i);
          held++;
        end
      end
      g = rand_gap();
      if (g > 0) begin
        res.ready = 1'b0;
        repeat (g) @(negedge clk_i);
      end
      res.ready = 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    shadow_t e;
    if (rst_ni && res.valid && res.ready) begin
      n_res++;
      if (pending_shadow.size() == 0) begin
        $error("result transfer with nothing expected");
        n_fail++;
      end else begin
        e = pending_shadow.pop_front();
        if (res.shadow_s !== e.s) begin
          $error("shadow_s: expected %0d, got %0d", $signed(e.s), res.shadow_s);
          n_fail++;
        end
        if (res.shadow_t !== e.t) begin
          $error("shadow_t: expected %0d, got %0d", $signed(e.t), res.shadow_t);
          n_fail++;
        end
        if (res.shadow_r !== e.r) begin
          $error("shadow_r: expected %0d, got %0d", $signed(e.r), res.shadow_r);
          n_fail++;
        end
        if (res.corner_index !== e.corner) begin
          $error("corner_index: expected %0d, got %0d", e.corner, res.corner_index);
          n_fail++;
        end
        if (res.last_of_pass !== e.last) begin
          $error("last_of_pass: expected %0d, got %0d", e.last, res.last_of_pass);
          n_fail++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    row_t rows [$];
    shadow_t none;
    logic [31:0] bset [5][3];
    n_fail = 0;
    n_vtx = 0;
    n_res = 0;
    cycles = 0;
    none = '0;
    corner_cnt = 0;
    for (int i = 0; i < 3; i++) begin
      ball[i] = 0;
      first_v[i] = 0;
      fnorm[i] = 0;
      frame_u[i] = 0;
      frame_v[i] = 0;
    end
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BALL_X;
    cfg_data_i = '0;
    vtx.valid = 1'b0;
    vtx.vert_x = '0;
    vtx.vert_y = '0;
    vtx.vert_z = '0;
    vtx.norm_x = '0;
    vtx.norm_y = '0;
    vtx.norm_z = '0;
    vtx.end_of_pass = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: single-vertex passes with readable results, then quads
    rows.push_back('{'{0, 0, 0, 0, 0, 18'sd65536, 1'b1}, 1'b1,
                     '{32'h8000, 32'h8000, 32'd0, 2'd0, 1'b1}});
    rows.push_back('{'{32'sh7FFF_FFFF, 0, 0, 18'sd65536, 0, 0, 1'b1}, 1'b1,
                     '{32'h8000, 32'h8000, 32'h8000_0001, 2'd0, 1'b1}});
    rows.push_back('{'{32'sh8000_0000, 0, 0, -18'sd65536, 0, 0, 1'b1}, 1'b1,
                     '{32'h8000, 32'h8000, 32'h8000_0000, 2'd0, 1'b1}});
    // unit square in the xy plane
    rows.push_back('{'{0, 0, 0, 0, 0, 18'sd65536, 1'b0}, 1'b0, none});
    rows.push_back('{'{32'sh1_0000, 0, 0, 0, 0, 0, 1'b0}, 1'b0, none});
    rows.push_back('{'{32'sh1_0000, 32'sh1_0000, 0, 0, 0, 0, 1'b0}, 1'b0, none});
    rows.push_back('{'{0, 32'sh1_0000, 0, 0, 0, 0, 1'b0}, 1'b0, none});
    // degenerate edge: zero-length u
    rows.push_back('{'{32'sh5_0000, 32'sh5_0000, 0, 18'sd65536, 0, 0, 1'b0}, 1'b0, none});
    rows.push_back('{'{32'sh5_0000, 32'sh5_0000, 0, 0, 0, 0, 1'b1}, 1'b0, none});
    // extreme corners, saturating projections
    rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       -18'sd65536, 0, 0, 1'b0}, 1'b0, none});
    rows.push_back('{'{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 0, 1'b0},
                     1'b0, none});
    rows.push_back('{'{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 0, 0, 1'b1}, 1'b0, none});
    // normal outside unit range, pass ends at corner 3
    rows.push_back('{'{32'sh1234, -32'sh5678, 32'sh9_0000, 18'sh1FFFF, 18'sh20000,
                       18'sh1FFFF, 1'b0}, 1'b0, none});
    rows.push_back('{'{-32'sh3_0000, 32'sh2_0000, 32'sh1_0000, 0, 0, 0, 1'b0}, 1'b0, none});
    rows.push_back('{'{32'sh4_0000, 32'sh4_0000, 0, 0, 0, 0, 1'b0}, 1'b0, none});
    rows.push_back('{'{32'sh0, -32'sh7_0000, 32'sh2_0000, 0, 0, 0, 1'b1}, 1'b0, none});
    // pass ending on corner 1
    rows.push_back('{'{32'sh1_0000, 0, 0, 0, 18'sd65536, 0, 1'b0}, 1'b0, none});
    rows.push_back('{'{0, 0, 32'sh2_0000, 0, 0, 0, 1'b1}, 1'b0, none});

    set_ball(32'd0, 32'd0, 32'd0);
    foreach (rows[i]) send_vertex(rows[i].vtx, rows[i].chk, rows[i].exp);
    drain();

    // Random phases under different ball positions
    bset[0] = '{32'h0001_8000, 32'hFFFE_0000, 32'h0000_4000};
    bset[1] = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
    bset[2] = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    bset[3] = '{$urandom(), $urandom(), $urandom()};
    bset[4] = '{32'($urandom_range(0, 32'h3F_FFFF)), 32'($urandom_range(0, 32'h3F_FFFF)),
                32'($urandom_range(0, 32'h3F_FFFF))};
    for (int ph = 0; ph < 5; ph++) begin
      set_ball(bset[ph][0], bset[ph][1], bset[ph][2]);
      for (int k = 0; k < NumRandom / 5; k++) send_vertex(rand_vertex(), 1'b0, none);
      drain();
    end

    $display("run covered %0d vertices and %0d results over six ball positions",
             n_vtx, n_res);
    $display("including a long receiver stall and passes ending on every corner");
    if (n_fail == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ quad_shadow_coord_projection.f @@
rtl/core/qscp_pkg.sv
rtl/core/qscp_if.sv
rtl/core/qscp_dp.sv
rtl/core/qscp_ctrl.sv
rtl/core/quad_shadow_coord_projection.sv
tb/sv/testbench.sv
